// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define TCP_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tcp assertion failed");

// checked at every edge, reset included
`define TCP_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("tcp assertion failed");

`endif

// ===== rtl/tcp_pkg.sv =====
package tcp_pkg;

	localparam int ADDR_W      = 28;
	localparam int OFFSET_BITS = 6;
	localparam int INDEX_BITS  = 10;
	localparam int TAG_BITS    = 12;
	localparam int COUNT_W     = 16;

	localparam int DEF_PATTERN_SET_BITS = 8;
	localparam int DEF_PATTERN_WAYS     = 8;
	localparam int DEF_HISTORY_SETS     = 1024;

	typedef logic [TAG_BITS-1:0]   tag_t;
	typedef logic [INDEX_BITS-1:0] index_t;
	typedef logic [COUNT_W-1:0]    count_t;

	typedef struct packed {
		tag_t   key;
		tag_t   nxt;
		count_t cnt;
	} way_t;

	typedef struct packed {
		tag_t newest;
		tag_t oldest;
	} hist_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HIST,
		ST_PAT,
		ST_LOOK
	} state_t;

endpackage

// ===== rtl/tcp_hist_mem.sv =====
module tcp_hist_mem #(
	parameter int AW = 10
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  tcp_pkg::hist_t  wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output tcp_pkg::hist_t  rdata
);

	tcp_pkg::hist_t mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tcp_pat_mem.sv =====
module tcp_pat_mem #(
	parameter int SET_BITS = 8,
	parameter int WAYS     = 8
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [SET_BITS-1:0]            waddr,
	input  tcp_pkg::way_t [WAYS-1:0]       wdata,
	input  logic                           re,
	input  logic [SET_BITS-1:0]            raddr,
	output tcp_pkg::way_t [WAYS-1:0]       rdata
);

	tcp_pkg::way_t [WAYS-1:0] mem [2**SET_BITS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/tag_correlation_prefetcher.sv =====
// an accepted beat goes through the HIST, PAT and LOOK states, and its result beat
// is registered out of LOOK once the output is free; a new access is taken only in
// IDLE, after the history read, the pattern read-modify-write and the dependent
// pattern lookup of the last one on the memories, which have one read port each
// reset: clears history and pattern memories one row a cycle, taking no beat meanwhile
`include "assert_macros.svh"

module tag_correlation_prefetcher #(
	parameter int PATTERN_SET_BITS = tcp_pkg::DEF_PATTERN_SET_BITS,
	parameter int PATTERN_WAYS     = tcp_pkg::DEF_PATTERN_WAYS,
	parameter int HISTORY_SETS     = tcp_pkg::DEF_HISTORY_SETS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [tcp_pkg::ADDR_W-1:0]  access_address,
	input  logic                        is_miss,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        prefetch_valid,
	output logic [tcp_pkg::ADDR_W-1:0]  prefetch_address
);

	localparam int HIST_AW   = $clog2(HISTORY_SETS);
	localparam int PAT_SETS  = 2 ** PATTERN_SET_BITS;
	localparam int CLR_LEN   = (HISTORY_SETS > PAT_SETS) ? HISTORY_SETS : PAT_SETS;
	localparam int CLR_W     = $clog2(CLR_LEN);
	localparam int WAY_AW    = (PATTERN_WAYS > 1) ? $clog2(PATTERN_WAYS) : 1;
	localparam int TAG_LSB   = tcp_pkg::OFFSET_BITS + tcp_pkg::INDEX_BITS;

	tcp_pkg::state_t state_q, state_d;
	logic [CLR_W-1:0] clr_q;

	logic [tcp_pkg::ADDR_W-1:0] addr_q;
	logic                       miss_q;
	tcp_pkg::hist_t             hist_q;
	logic [PATTERN_SET_BITS-1:0] set_q;
	logic                       fwd_q;
	tcp_pkg::way_t [PATTERN_WAYS-1:0] fwd_row_q;

	logic out_valid_q, pref_valid_q;
	logic [tcp_pkg::ADDR_W-1:0] pref_addr_q;

	logic accept, out_load, out_free;

	logic                hist_we, hist_re;
	logic [HIST_AW-1:0]  hist_waddr, hist_raddr;
	tcp_pkg::hist_t      hist_wdata, hist_rdata;

	logic                          pat_we, pat_re;
	logic [PATTERN_SET_BITS-1:0]   pat_waddr, pat_raddr;
	tcp_pkg::way_t [PATTERN_WAYS-1:0] pat_wdata, pat_rdata;

	tcp_pkg::index_t cur_idx, in_idx;
	tcp_pkg::tag_t   cur_tag;
	logic [HIST_AW-1:0] cur_hidx;
	logic [tcp_pkg::TAG_BITS:0] upd_sum, look_sum;
	logic [PATTERN_SET_BITS-1:0] look_set;

	logic              hit;
	logic [WAY_AW-1:0] hit_w, least_w;
	tcp_pkg::count_t   least_v;
	tcp_pkg::way_t [PATTERN_WAYS-1:0] new_row, look_row;

	logic              found;
	tcp_pkg::tag_t     found_nxt;
	logic [tcp_pkg::ADDR_W-1:0] pred;

	tcp_hist_mem #(.AW(HIST_AW)) u_hist (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.re    (hist_re),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	tcp_pat_mem #(.SET_BITS(PATTERN_SET_BITS), .WAYS(PATTERN_WAYS)) u_pat (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_waddr),
		.wdata (pat_wdata),
		.re    (pat_re),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	assign in_idx   = access_address[tcp_pkg::OFFSET_BITS +: tcp_pkg::INDEX_BITS];
	assign cur_idx  = addr_q[tcp_pkg::OFFSET_BITS +: tcp_pkg::INDEX_BITS];
	assign cur_tag  = addr_q[TAG_LSB +: tcp_pkg::TAG_BITS];
	assign cur_hidx = HIST_AW'(cur_idx);

	assign out_free = !out_valid_q || !out_stall;
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == tcp_pkg::ST_LOOK) && out_free;

	// learning step on the pattern row
	always_comb begin
		hit     = 1'b0;
		hit_w   = '0;
		least_v = pat_rdata[0].cnt;
		least_w = '0;
		for (int w = 0; w < PATTERN_WAYS; w++) begin
			if (pat_rdata[w].key == hist_q.newest) begin
				hit   = 1'b1;
				hit_w = WAY_AW'(w);
			end
			if (pat_rdata[w].cnt < least_v) begin
				least_v = pat_rdata[w].cnt;
				least_w = WAY_AW'(w);
			end
		end
		new_row = pat_rdata;
		if (hit) begin
			new_row[hit_w].nxt = cur_tag;
			if (pat_rdata[hit_w].cnt != '1) begin
				new_row[hit_w].cnt = pat_rdata[hit_w].cnt + 1'b1;
			end
		end else begin
			new_row[least_w].key = hist_q.newest;
			new_row[least_w].nxt = cur_tag;
			new_row[least_w].cnt = tcp_pkg::count_t'(1);
		end
	end

	assign upd_sum  = {1'b0, hist_rdata.oldest} + {1'b0, hist_rdata.newest};
	assign look_sum = {1'b0, hist_q.newest} + {1'b0, cur_tag};
	assign look_set = miss_q ? look_sum[PATTERN_SET_BITS-1:0] : set_q;

	// prediction from the lookup row, first match
	always_comb begin
		look_row  = fwd_q ? fwd_row_q : pat_rdata;
		found     = 1'b0;
		found_nxt = '0;
		for (int w = PATTERN_WAYS - 1; w >= 0; w--) begin
			if (look_row[w].key == cur_tag) begin
				found     = 1'b1;
				found_nxt = look_row[w].nxt;
			end
		end
		pred = {found_nxt, cur_idx, {tcp_pkg::OFFSET_BITS{1'b0}}};
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tcp_pkg::ST_CLEAR: begin
				if (clr_q == CLR_W'(CLR_LEN - 1)) begin
					state_d = tcp_pkg::ST_IDLE;
				end
			end
			tcp_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = tcp_pkg::ST_HIST;
				end
			end
			tcp_pkg::ST_HIST: state_d = tcp_pkg::ST_PAT;
			tcp_pkg::ST_PAT:  state_d = tcp_pkg::ST_LOOK;
			tcp_pkg::ST_LOOK: begin
				if (out_free) begin
					state_d = tcp_pkg::ST_IDLE;
				end
			end
			default: state_d = tcp_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		in_stall   = 1'b1;
		hist_we    = 1'b0;
		hist_waddr = cur_hidx;
		hist_wdata = '{newest: cur_tag, oldest: hist_q.newest};
		hist_re    = 1'b0;
		hist_raddr = HIST_AW'(in_idx);
		pat_we     = 1'b0;
		pat_waddr  = set_q;
		pat_wdata  = new_row;
		pat_re     = 1'b0;
		pat_raddr  = look_set;
		case (state_q)
			tcp_pkg::ST_CLEAR: begin
				hist_we    = ({1'b0, clr_q} < (CLR_W + 1)'(HISTORY_SETS));
				hist_waddr = HIST_AW'(clr_q);
				hist_wdata = '0;
				pat_we     = ({1'b0, clr_q} < (CLR_W + 1)'(PAT_SETS));
				pat_waddr  = PATTERN_SET_BITS'(clr_q);
				pat_wdata  = '0;
			end
			tcp_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				hist_re  = 1'b1;
			end
			tcp_pkg::ST_HIST: begin
				pat_re    = 1'b1;
				pat_raddr = upd_sum[PATTERN_SET_BITS-1:0];
			end
			tcp_pkg::ST_PAT: begin
				hist_we = miss_q;
				pat_we  = miss_q;
				pat_re  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tcp_pkg::ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == tcp_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == tcp_pkg::ST_PAT) begin
				fwd_q <= miss_q && (look_set == set_q);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= access_address;
			miss_q <= is_miss;
		end
		if (state_q == tcp_pkg::ST_HIST) begin
			hist_q <= hist_rdata;
			set_q  <= upd_sum[PATTERN_SET_BITS-1:0];
		end
		if (state_q == tcp_pkg::ST_PAT) begin
			fwd_row_q <= new_row;
		end
		if (out_load) begin
			pref_valid_q <= found && (pred != '0);
			pref_addr_q  <= (found && (pred != '0)) ? pred : '0;
		end
	end

	assign out_valid        = out_valid_q;
	assign prefetch_valid   = pref_valid_q;
	assign prefetch_address = pref_addr_q;

	`TCP_ASSERT(a_accept_to_look, accept |-> ##3 (state_q == tcp_pkg::ST_LOOK))
	`TCP_ASSERT(a_pat_write_phase, pat_we |-> (state_q == tcp_pkg::ST_PAT || state_q == tcp_pkg::ST_CLEAR))
	`TCP_ASSERT(a_fwd_only_miss, (state_q == tcp_pkg::ST_LOOK) && !miss_q |-> !fwd_q)
	`TCP_ASSERT_ALWAYS(a_reset_clear, !arst_n |=> (state_q == tcp_pkg::ST_CLEAR && !out_valid_q))

endmodule
